[hw/rtl/tocs_pkg.sv]
// Shared types and constants for the output-compare timer scheduler.
// No dependencies; every other file of the block imports this package.

package tocs_pkg;

    // Widths of the timer datapath.
    localparam int CounterBits  = 16;
    localparam int OverflowBits = 16;
    localparam int PrescaleBits = 3;
    localparam int DividerBits  = 7;
    localparam int CycleBits    = 16;
    localparam int ShotBits     = 16;
    localparam int ElapsedBits  = 32;
    localparam int CfgIndexBits = 2;
    localparam int CfgDataBits  = 16;

    // Timer counts at 8 MHz at the undivided rate, so one count is 1/8 us.
    localparam int UsShift = 3;

    // Register reset values.
    localparam logic [PrescaleBits-1:0] PrescaleReset     = '0;
    localparam logic [CycleBits-1:0]    PeriodCyclesReset = CycleBits'(1);
    localparam logic [ShotBits-1:0]     PeriodShotsReset  = '0;

    // Request action codes.
    typedef enum logic [1:0] {
        ACT_TICK           = 2'd0,
        ACT_ARM_ONESHOT    = 2'd1,
        ACT_START_PERIODIC = 2'd2,
        ACT_CLEAR          = 2'd3
    } action_t;

    // Configuration register indexes.
    typedef enum logic [CfgIndexBits-1:0] {
        REG_PRESCALE      = 2'd0,
        REG_PERIOD_CYCLES = 2'd1,
        REG_PERIOD_SHOTS  = 2'd2
    } cfg_reg_t;

    // Payload of one request.
    typedef struct packed {
        action_t              action;
        logic [CycleBits-1:0] oneshot_cycles;
        logic [ShotBits-1:0]  oneshot_shots;
    } request_t;

    // Payload of one result.
    typedef struct packed {
        logic                   periodic_fire;
        logic                   oneshot_fire;
        logic [ElapsedBits-1:0] elapsed_us;
    } result_t;

    // Timebase status handed from the counter to the compare channels.
    typedef struct packed {
        logic                    advance;
        logic [CounterBits-1:0]  count_cur;
        logic [CounterBits-1:0]  count_next;
        logic [OverflowBits-1:0] overflow_next;
    } timebase_t;

    // Compare channel firing flags.
    typedef struct packed {
        logic periodic;
        logic oneshot;
    } fire_t;

endpackage

[hw/rtl/tocs_request_if.sv]
// Request channel of the output-compare timer: valid, ready and payload.
// Depends on tocs_pkg for the payload type.

interface tocs_request_if import tocs_pkg::*;;

    logic     valid;
    logic     ready;
    request_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

[hw/rtl/tocs_result_if.sv]
// Result channel of the output-compare timer: valid, ready and payload.
// Depends on tocs_pkg for the payload type.

interface tocs_result_if import tocs_pkg::*;;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

[hw/rtl/tocs_timebase.sv]
// Prescaler, free-running counter and overflow counter of the timer.
// Depends on tocs_pkg; state moves only when a request is accepted.

module tocs_timebase import tocs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  action_t                 action,
    input  logic [PrescaleBits-1:0] prescale,
    output timebase_t               tb
);

    logic [DividerBits-1:0]  prescale_count_reg;
    logic [DividerBits-1:0]  prescale_count_next;
    logic [CounterBits-1:0]  timer_count_reg;
    logic [CounterBits-1:0]  timer_count_next;
    logic [OverflowBits-1:0] overflow_count_reg;
    logic [OverflowBits-1:0] overflow_count_next;
    logic [DividerBits-1:0]  limit;
    logic                    advance;

    // The counter steps once the divider has reached or passed its limit.
    assign limit   = DividerBits'((1 << prescale) - 1);
    assign advance = (action == ACT_TICK) && (prescale_count_reg >= limit);

    // Next state of the prescaler and counters.
    always_comb
    begin
        prescale_count_next = prescale_count_reg;
        timer_count_next    = timer_count_reg;
        overflow_count_next = overflow_count_reg;
        case (action)
            ACT_TICK:
            begin
                if (advance)
                begin
                    prescale_count_next = '0;
                    timer_count_next    = timer_count_reg + CounterBits'(1);
                    if (timer_count_next == '0)
                    begin
                        overflow_count_next = overflow_count_reg + OverflowBits'(1);
                    end
                end
                else
                begin
                    prescale_count_next = prescale_count_reg + DividerBits'(1);
                end
            end
            ACT_CLEAR:
            begin
                prescale_count_next = '0;
                timer_count_next    = '0;
            end
            default:
            begin
                prescale_count_next = prescale_count_reg;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg <= '0;
            timer_count_reg    <= '0;
            overflow_count_reg <= '0;
        end
        else if (accept)
        begin
            prescale_count_reg <= prescale_count_next;
            timer_count_reg    <= timer_count_next;
            overflow_count_reg <= overflow_count_next;
        end
    end

    assign tb.advance       = advance;
    assign tb.count_cur     = timer_count_reg;
    assign tb.count_next    = timer_count_next;
    assign tb.overflow_next = overflow_count_next;

    // A counter step always restarts the divider.
    a_step_restarts_divider: assert property (@(posedge clk) disable iff (!rst_n)
        accept && advance |=> prescale_count_reg == '0)
        else $error("prescaler not restarted after a counter step");

endmodule

[hw/rtl/tocs_channels.sv]
// Periodic and one-shot compare channels of the timer.
// Depends on tocs_pkg; takes the timebase status from tocs_timebase.

module tocs_channels import tocs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  action_t              action,
    input  logic [CycleBits-1:0] oneshot_cycles,
    input  logic [ShotBits-1:0]  oneshot_shots,
    input  logic [CycleBits-1:0] period_cycles,
    input  logic [ShotBits-1:0]  period_shots,
    input  timebase_t            tb,
    output fire_t                fire
);

    logic [CounterBits-1:0] periodic_compare_reg;
    logic [CounterBits-1:0] periodic_compare_next;
    logic [ShotBits-1:0]    periodic_remaining_reg;
    logic [ShotBits-1:0]    periodic_remaining_next;
    logic                   periodic_active_reg;
    logic                   periodic_active_next;
    logic [CounterBits-1:0] oneshot_compare_reg;
    logic [CounterBits-1:0] oneshot_compare_next;
    logic [ShotBits-1:0]    oneshot_remaining_reg;
    logic [ShotBits-1:0]    oneshot_remaining_next;
    logic                   oneshot_armed_reg;
    logic                   oneshot_armed_next;
    logic                   periodic_match;
    logic                   oneshot_match;

    // Matches are tested against the counter value after it steps.
    assign periodic_match = tb.advance && periodic_active_reg
                            && (tb.count_next == periodic_compare_reg);
    assign oneshot_match  = tb.advance && oneshot_armed_reg
                            && (tb.count_next == oneshot_compare_reg);

    assign fire.periodic = periodic_match && (periodic_remaining_reg == '0);
    assign fire.oneshot  = oneshot_match && (oneshot_remaining_reg == '0);

    // Next state of both channels.
    always_comb
    begin
        periodic_compare_next   = periodic_compare_reg;
        periodic_remaining_next = periodic_remaining_reg;
        periodic_active_next    = periodic_active_reg;
        oneshot_compare_next    = oneshot_compare_reg;
        oneshot_remaining_next  = oneshot_remaining_reg;
        oneshot_armed_next      = oneshot_armed_reg;
        case (action)
            ACT_TICK:
            begin
                if (periodic_match)
                begin
                    if (fire.periodic)
                    begin
                        periodic_remaining_next = period_shots;
                        periodic_compare_next   = periodic_compare_reg
                                                  + CounterBits'(period_cycles);
                    end
                    else
                    begin
                        periodic_remaining_next = periodic_remaining_reg - ShotBits'(1);
                    end
                end
                if (oneshot_match)
                begin
                    if (fire.oneshot)
                    begin
                        oneshot_armed_next = 1'b0;
                    end
                    else
                    begin
                        oneshot_remaining_next = oneshot_remaining_reg - ShotBits'(1);
                    end
                end
            end
            ACT_ARM_ONESHOT:
            begin
                oneshot_compare_next   = tb.count_cur + CounterBits'(oneshot_cycles);
                oneshot_remaining_next = oneshot_shots;
                oneshot_armed_next     = 1'b1;
            end
            ACT_START_PERIODIC:
            begin
                periodic_compare_next   = tb.count_cur + CounterBits'(period_cycles);
                periodic_remaining_next = period_shots;
                periodic_active_next    = 1'b1;
            end
            default:
            begin
                oneshot_armed_next = oneshot_armed_reg;
            end
        endcase
    end

    // Channel state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            periodic_compare_reg   <= '0;
            periodic_remaining_reg <= '0;
            periodic_active_reg    <= 1'b0;
            oneshot_compare_reg    <= '0;
            oneshot_remaining_reg  <= '0;
            oneshot_armed_reg      <= 1'b0;
        end
        else if (accept)
        begin
            periodic_compare_reg   <= periodic_compare_next;
            periodic_remaining_reg <= periodic_remaining_next;
            periodic_active_reg    <= periodic_active_next;
            oneshot_compare_reg    <= oneshot_compare_next;
            oneshot_remaining_reg  <= oneshot_remaining_next;
            oneshot_armed_reg      <= oneshot_armed_next;
        end
    end

    // A one-shot firing disarms its channel.
    a_oneshot_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        accept && fire.oneshot |=> !oneshot_armed_reg)
        else $error("one-shot channel still armed after firing");

    // A periodic firing reloads the skip count from the register.
    a_periodic_reload: assert property (@(posedge clk) disable iff (!rst_n)
        accept && fire.periodic |=> periodic_remaining_reg == $past(period_shots))
        else $error("periodic skip count not reloaded after firing");

endmodule

[hw/rtl/timer_output_compare_scheduler.sv]
// Top level of the output-compare timer scheduler.
// Depends on tocs_pkg, tocs_request_if, tocs_result_if, tocs_timebase, tocs_channels.
//
// Usage:
// - Each request on the request channel is one action: a timer tick, arming
//   the one-shot channel, starting the periodic channel or clearing the counter.
// - Every request gives exactly one result on the result channel, carrying the
//   periodic and one-shot firing flags and the elapsed time in microseconds.
// - The result of a request accepted at one edge is valid from the next edge.
//   Throughput is one request per cycle while the receiver takes each result;
//   all state updates are done between the request and the result register.
// - A one-entry result register decouples the channels. While it holds an
//   untaken result and the receiver stalls, request ready is low; ready returns
//   in the cycle the receiver takes the result, so a new request is accepted
//   whilst the old result is being delivered.
// - Configuration writes (prescale, period cycles, period shots) are taken on
//   any edge with cfg_write high and are meant for idle periods only.
// - Reset clears the timer, the overflow count, both channels and the result
//   valid flag, and returns the configuration registers to their defaults.

module timer_output_compare_scheduler import tocs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CfgIndexBits-1:0] cfg_index,
    input  logic [CfgDataBits-1:0]  cfg_data,
    tocs_request_if.sink            request,
    tocs_result_if.source           result
);

    logic [PrescaleBits-1:0] prescale_reg;
    logic [CycleBits-1:0]    period_cycles_reg;
    logic [ShotBits-1:0]     period_shots_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    result_t                 out_data_reg;
    logic                    accept;
    timebase_t               tb;
    fire_t                   fire;
    logic [ElapsedBits-1:0]  count_wide;
    logic [ElapsedBits-1:0]  elapsed;

    // Handshake: accept whenever the result register is free or being emptied.
    assign request.ready = !out_valid_reg || result.ready;
    assign accept        = request.valid && request.ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg      <= PrescaleReset;
            period_cycles_reg <= PeriodCyclesReset;
            period_shots_reg  <= PeriodShotsReset;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PRESCALE:      prescale_reg      <= PrescaleBits'(cfg_data);
                REG_PERIOD_CYCLES: period_cycles_reg <= CycleBits'(cfg_data);
                REG_PERIOD_SHOTS:  period_shots_reg  <= ShotBits'(cfg_data);
                default:           prescale_reg      <= prescale_reg;
            endcase
        end
    end

    // Prescaler and counters.
    tocs_timebase u_timebase (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .action   (request.data.action),
        .prescale (prescale_reg),
        .tb       (tb)
    );

    // Compare channels.
    tocs_channels u_channels (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .action         (request.data.action),
        .oneshot_cycles (request.data.oneshot_cycles),
        .oneshot_shots  (request.data.oneshot_shots),
        .period_cycles  (period_cycles_reg),
        .period_shots   (period_shots_reg),
        .tb             (tb),
        .fire           (fire)
    );

    // Elapsed time from the updated counters, scaled by the divider.
    assign count_wide = (ElapsedBits'(tb.overflow_next) << CounterBits)
                        | ElapsedBits'(tb.count_next);

    always_comb
    begin
        if (prescale_reg < PrescaleBits'(UsShift))
        begin
            elapsed = count_wide >> (PrescaleBits'(UsShift) - prescale_reg);
        end
        else
        begin
            elapsed = count_wide << (prescale_reg - PrescaleBits'(UsShift));
        end
    end

    // Result register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, loaded with every accepted request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg.periodic_fire <= fire.periodic;
            out_data_reg.oneshot_fire  <= fire.oneshot;
            out_data_reg.elapsed_us    <= elapsed;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // Every accepted request is presented as a result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result.valid)
        else $error("accepted request produced no result");

    // Actions other than a tick never fire a channel.
    a_no_fire_off_tick: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (request.data.action != ACT_TICK)
        |=> !result.data.periodic_fire && !result.data.oneshot_fire)
        else $error("channel fired on a non-tick action");

endmodule

[verif/tb_timer_output_compare_scheduler.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the output-compare timer scheduler.
// Depends on tocs_pkg, tocs_request_if, tocs_result_if and the top level RTL.

module tb_timer_output_compare_scheduler;
    import tocs_pkg::*;

    localparam int StallLimit = 1000;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CfgIndexBits-1:0] cfg_index;
    logic [CfgDataBits-1:0] cfg_data;

    tocs_request_if request_ch ();
    tocs_result_if result_ch ();

    timer_output_compare_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request_ch),
        .result    (result_ch)
    );

    // Shadow copy of the timer: registers and state.
    logic [PrescaleBits-1:0] shadow_prescale;
    logic [CycleBits-1:0]    shadow_period_cycles;
    logic [ShotBits-1:0]     shadow_period_shots;
    logic [DividerBits-1:0]  shadow_divider;
    logic [CounterBits-1:0]  shadow_count;
    logic [OverflowBits-1:0] shadow_overflow;
    logic [CounterBits-1:0]  periodic_match;
    logic [ShotBits-1:0]     periodic_skips;
    logic                    periodic_running;
    logic [CounterBits-1:0]  oneshot_match;
    logic [ShotBits-1:0]     oneshot_skips;
    logic                    oneshot_pending;

    result_t     pending_results[$];
    int unsigned mismatches;
    int unsigned idle_cycles;
    logic        request_taken;
    logic        source_gaps_on;
    logic        sink_stalls_on;
    int unsigned sink_hold;

    // Clock: 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Returns the state of the shadow timer to its reset values.
    task automatic reset_shadow();
        shadow_prescale      = PrescaleReset;
        shadow_period_cycles = PeriodCyclesReset;
        shadow_period_shots  = PeriodShotsReset;
        shadow_divider       = '0;
        shadow_count         = '0;
        shadow_overflow      = '0;
        periodic_match       = '0;
        periodic_skips       = '0;
        periodic_running     = 1'b0;
        oneshot_match        = '0;
        oneshot_skips        = '0;
        oneshot_pending      = 1'b0;
    endtask

    // Applies one request to the shadow timer and returns the result it should give.
    function automatic result_t timer_response(input request_t req);
        result_t     res;
        int unsigned limit;
        logic [ElapsedBits-1:0] total;
        res = '0;
        case (req.action)
            ACT_TICK:
            begin
                limit = (32'd1 << shadow_prescale) - 1;
                if (shadow_divider >= limit)
                begin
                    shadow_divider = '0;
                    shadow_count = shadow_count + 1'b1;
                    if (shadow_count == '0)
                        shadow_overflow = shadow_overflow + 1'b1;
                    // Compares are only looked at when the counter moves.
                    if (periodic_running && shadow_count == periodic_match)
                    begin
                        if (periodic_skips == '0)
                        begin
                            periodic_skips = shadow_period_shots;
                            periodic_match = periodic_match + shadow_period_cycles;
                            res.periodic_fire = 1'b1;
                        end
                        else
                            periodic_skips = periodic_skips - 1'b1;
                    end
                    if (oneshot_pending && shadow_count == oneshot_match)
                    begin
                        if (oneshot_skips == '0)
                        begin
                            oneshot_pending = 1'b0;
                            res.oneshot_fire = 1'b1;
                        end
                        else
                            oneshot_skips = oneshot_skips - 1'b1;
                    end
                end
                else
                    shadow_divider = shadow_divider + 1'b1;
            end
            ACT_ARM_ONESHOT:
            begin
                oneshot_match   = shadow_count + req.oneshot_cycles;
                oneshot_skips   = req.oneshot_shots;
                oneshot_pending = 1'b1;
            end
            ACT_START_PERIODIC:
            begin
                periodic_match   = shadow_count + shadow_period_cycles;
                periodic_skips   = shadow_period_shots;
                periodic_running = 1'b1;
            end
            default:
            begin
                shadow_count   = '0;
                shadow_divider = '0;
            end
        endcase
        // Elapsed time: one undivided count is an eighth of a microsecond.
        total = {shadow_overflow, shadow_count};
        if (int'(shadow_prescale) < UsShift)
            res.elapsed_us = total >> (UsShift - int'(shadow_prescale));
        else
            res.elapsed_us = total << (int'(shadow_prescale) - UsShift);
        return res;
    endfunction

    // Accepted requests are run through the shadow timer.
    always @(posedge clk)
    begin
        request_taken = rst_n && request_ch.valid && request_ch.ready;
        if (request_taken)
            pending_results.push_back(timer_response(request_ch.data));
    end

    task automatic report_mismatch(input string field, input longint unsigned want,
                                   input longint unsigned got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    // Each accepted result is compared with the oldest outstanding prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         result_ch.data);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.data.periodic_fire !== want.periodic_fire)
                    report_mismatch("periodic_fire", want.periodic_fire,
                                    result_ch.data.periodic_fire);
                if (result_ch.data.oneshot_fire !== want.oneshot_fire)
                    report_mismatch("oneshot_fire", want.oneshot_fire,
                                    result_ch.data.oneshot_fire);
                if (result_ch.data.elapsed_us !== want.elapsed_us)
                    report_mismatch("elapsed_us", want.elapsed_us, result_ch.data.elapsed_us);
            end
        end
    end

    // The run is abandoned when neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((request_ch.valid && request_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= StallLimit)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Gap length: mostly short, now and then a long one.
    function automatic int unsigned random_gap();
        if ($urandom_range(99) < 80)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Result receiver with random stalls.
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (sink_hold != 0)
        begin
            sink_hold--;
            result_ch.ready <= 1'b0;
        end
        else if (sink_stalls_on && $urandom_range(99) < 15)
        begin
            sink_hold = random_gap() - 1;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= 1'b1;
    end

    // Sends one request; entered and left at a falling edge.
    task automatic send_request(input action_t act, input logic [CycleBits-1:0] cycles,
                                input logic [ShotBits-1:0] shots);
        int unsigned gap;
        gap = 0;
        if (source_gaps_on && $urandom_range(99) < 25)
            gap = random_gap();
        if (gap != 0)
        begin
            request_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        request_ch.valid <= 1'b1;
        request_ch.data  <= {act, cycles, shots};
        do
            @(negedge clk);
        while (!request_taken);
    endtask

    task automatic send_ticks(input int unsigned count);
        repeat (count) send_request(ACT_TICK, CycleBits'($urandom), ShotBits'($urandom));
    endtask

    // Holds back requests until every result has been delivered.
    task automatic wait_for_results();
        request_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // Writes one register; the caller lowers the write enable afterwards.
    task automatic write_register(input cfg_reg_t index, input logic [CfgDataBits-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        case (index)
            REG_PRESCALE:      shadow_prescale      = value[PrescaleBits-1:0];
            REG_PERIOD_CYCLES: shadow_period_cycles = value[CycleBits-1:0];
            default:           shadow_period_shots  = value[ShotBits-1:0];
        endcase
    endtask

    // Reprograms all three registers once the block is idle.
    task automatic configure(input logic [PrescaleBits-1:0] prescale,
                             input logic [CycleBits-1:0] cycles,
                             input logic [ShotBits-1:0] shots);
        wait_for_results();
        write_register(REG_PRESCALE, CfgDataBits'(prescale));
        write_register(REG_PERIOD_CYCLES, cycles);
        write_register(REG_PERIOD_SHOTS, shots);
        cfg_write <= 1'b0;
    endtask

    // Every action at the reset settings, extreme fields, rearming and clearing.
    task automatic test_directed_actions();
        send_ticks(2);
        send_request(ACT_START_PERIODIC, 16'h0000, 16'h0000);
        send_ticks(2);
        send_request(ACT_ARM_ONESHOT, 16'd2, 16'd0);
        send_ticks(2);
        send_request(ACT_ARM_ONESHOT, 16'hFFFF, 16'hFFFF);
        send_ticks(1);
        // A zero offset matches the current count, so clear and count back up to it.
        send_request(ACT_ARM_ONESHOT, 16'd0, 16'd0);
        send_request(ACT_CLEAR, 16'hFFFF, 16'hFFFF);
        send_ticks(7);
        // Rearming replaces the earlier one-shot compare.
        send_request(ACT_ARM_ONESHOT, 16'd5, 16'd0);
        send_request(ACT_ARM_ONESHOT, 16'd1, 16'd0);
        send_ticks(2);
    endtask

    // Divider changes, including lowering it while part way through a count.
    task automatic test_prescale_changes();
        configure(3'd3, 16'd2, 16'd1);
        send_request(ACT_START_PERIODIC, 16'h5A5A, 16'hA5A5);
        send_ticks(3);
        configure(3'd1, 16'd2, 16'd1);
        send_ticks(3);
        configure(3'd7, 16'd2, 16'd1);
        send_ticks(5);
        configure(3'd0, 16'd1, 16'd0);
        send_ticks(3);
    endtask

    // A burst at full rate with a zero period and a one-shot that skips a match.
    task automatic test_counter_wrap();
        source_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        configure(3'd0, 16'd0, 16'd0);
        send_request(ACT_CLEAR, 16'h0000, 16'h0000);
        send_request(ACT_START_PERIODIC, 16'h0000, 16'h0000);
        send_request(ACT_ARM_ONESHOT, 16'd0, 16'd1);
        send_ticks(64);
        source_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    // One random request: mostly ticks, with arms mostly a short way ahead.
    task automatic send_random_request();
        int unsigned pick;
        logic [CycleBits-1:0] cycles;
        logic [ShotBits-1:0] shots;
        pick   = $urandom_range(99);
        cycles = ($urandom_range(99) < 80) ? CycleBits'($urandom_range(12)) :
                                             CycleBits'($urandom);
        if ($urandom_range(99) < 75)
            shots = '0;
        else if ($urandom_range(99) < 60)
            shots = ShotBits'($urandom_range(3, 1));
        else
            shots = ShotBits'($urandom);
        if ($urandom_range(99) == 0)
            wait_for_results();
        if (pick < 70)
            send_request(ACT_TICK, CycleBits'($urandom), ShotBits'($urandom));
        else if (pick < 82)
            send_request(ACT_ARM_ONESHOT, cycles, shots);
        else if (pick < 92)
            send_request(ACT_START_PERIODIC, cycles, shots);
        else
            send_request(ACT_CLEAR, cycles, shots);
    endtask

    // Random traffic under a series of register settings.
    task automatic test_random_phases();
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: configure(3'd0, 16'd1, 16'd0);
                1: configure(3'd7, 16'hFFFF, 16'hFFFF);
                2: configure(3'd1, 16'd0, 16'd2);
                3: configure(3'd3, 16'd5, 16'd1);
                4: configure(3'd0, 16'd3, 16'd0);
                5: configure(3'd2, 16'hFFFF, 16'd0);
                6: configure(3'd7, 16'd1, 16'd0);
                default: configure(3'd5, 16'd7, 16'd0);
            endcase
            // One phase runs without any idling on either side.
            source_gaps_on = (phase != 4);
            sink_stalls_on = (phase != 4);
            repeat (205) send_random_request();
        end
    endtask

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_write        = 1'b0;
        cfg_index        = REG_PRESCALE;
        cfg_data         = '0;
        request_ch.valid = 1'b0;
        request_ch.data  = '0;
        result_ch.ready  = 1'b0;
        request_taken    = 1'b0;
        mismatches       = 0;
        idle_cycles      = 0;
        sink_hold        = 0;
        source_gaps_on   = 1'b1;
        sink_stalls_on   = 1'b1;
        reset_shadow();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_actions();
        test_prescale_changes();
        test_counter_wrap();
        test_random_phases();

        // Drain and give the result register time to show anything stray.
        request_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[timer_output_compare_scheduler.f]
hw/rtl/tocs_pkg.sv
hw/rtl/tocs_request_if.sv
hw/rtl/tocs_result_if.sv
hw/rtl/tocs_timebase.sv
hw/rtl/tocs_channels.sv
hw/rtl/timer_output_compare_scheduler.sv
verif/tb_timer_output_compare_scheduler.sv
